// ===== src/rsc_pkg.sv =====
// Shared constants and helpers for the Rabbit stream cipher block.
`default_nettype none
package rsc_pkg;
  localparam int unsigned CfgWidth = 64;
  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] REG_KEY_LOW = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_IV = 2'd2;

  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_KEY = 2'd1;
  localparam logic [1:0] CMD_IV = 2'd2;

  localparam logic [31:0] A0 = 32'h4D34D34D;
  localparam logic [31:0] A1 = 32'hD34D34D3;
  localparam logic [31:0] A2 = 32'h34D34D34;
  localparam logic [31:0] HI_MASK = 32'hFFFF0000;
  localparam logic [31:0] LO_MASK = 32'h0000FFFF;

  function automatic logic [31:0] step_add(input logic [2:0] i);
    logic [31:0] r;
    begin
      case (i)
        3'd0, 3'd3, 3'd6: r = A0;
        3'd1, 3'd4, 3'd7: r = A1;
        default: r = A2;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] rol16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] rol8(input logic [31:0] v);
    return {v[23:0], v[31:24]};
  endfunction
endpackage
`default_nettype wire

// ===== src/rsc_if.sv =====
// Valid/ready stream interfaces for the cipher input and output.
`default_nettype none
interface rsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic       end_of_call;
  modport source (output valid, command, data_byte, end_of_call, input ready);
  modport sink (input valid, command, data_byte, end_of_call, output ready);
endinterface

interface rsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  modport source (output valid, out_byte, is_data, input ready);
  modport sink (input valid, out_byte, is_data, output ready);
endinterface
`default_nettype wire

// ===== src/rabbit_stream_cipher_top.sv =====
// Rabbit stream cipher: top level with sequencer and shared squaring unit.
// Data byte at keystream position 1..15: XORed with the keystream byte in S_DECIDE and registered.
// Position 0 adds one iteration first: 8 carry-add steps, 8 squarings, 8 mixes
// and a wrap-up step that refills the keystream words.
// Key setup: 4 iterations, 8 counter fixes and a copy step; IV setup: 4 iterations.
// One item at a time; result held until transferred. Sync reset clears state to zero, except dbyte, g and sq.
`default_nettype none
module rabbit_stream_cipher_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [rsc_pkg::CfgIdxWidth-1:0] cfg_index,
  input  wire logic [rsc_pkg::CfgWidth-1:0] cfg_data,
  rsc_in_if.sink   in_ch,
  rsc_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CNT, S_SQ, S_SQW, S_MIX, S_ITDONE, S_FIX, S_KS, S_OUT
  } state_t;
  typedef enum logic [1:0] {J_DATA, J_KEY, J_IV} job_t;

  state_t state;
  job_t   job;
  logic [63:0] key_low, key_high, iv_value;
  logic [31:0] x [8];
  logic [31:0] c [8];
  logic        carry;
  logic [31:0] mx [8];
  logic [31:0] mc [8];
  logic        mcarry;
  logic [31:0] g [8];
  logic [31:0] ks [4];
  logic [3:0]  pos;
  logic [2:0]  idx;
  logic [1:0]  iter;
  logic [7:0]  dbyte;
  logic [63:0] sq;
  logic [31:0] sq_in;

  // Shared units: one 33-bit adder for the counters, one squarer.
  logic [32:0] cnt_sum;
  assign cnt_sum = {1'b0, c[idx]} + {1'b0, rsc_pkg::step_add(idx)} + {32'd0, carry};
  assign sq_in = x[idx] + c[idx];

  logic [31:0] mix_val;
  always_comb begin
    case (idx)
      3'd0: mix_val = g[0] + rsc_pkg::rol16(g[7]) + rsc_pkg::rol16(g[6]);
      3'd1: mix_val = g[1] + rsc_pkg::rol8(g[0]) + g[7];
      3'd2: mix_val = g[2] + rsc_pkg::rol16(g[1]) + rsc_pkg::rol16(g[0]);
      3'd3: mix_val = g[3] + rsc_pkg::rol8(g[2]) + g[1];
      3'd4: mix_val = g[4] + rsc_pkg::rol16(g[3]) + rsc_pkg::rol16(g[2]);
      3'd5: mix_val = g[5] + rsc_pkg::rol8(g[4]) + g[3];
      3'd6: mix_val = g[6] + rsc_pkg::rol16(g[5]) + rsc_pkg::rol16(g[4]);
      default: mix_val = g[7] + rsc_pkg::rol8(g[6]) + g[5];
    endcase
  end

  logic [31:0] k0, k1, k2, k3, v0, v1, v2, v3;
  assign k0 = key_low[31:0];
  assign k1 = key_low[63:32];
  assign k2 = key_high[31:0];
  assign k3 = key_high[63:32];
  assign v0 = iv_value[31:0];
  assign v2 = iv_value[63:32];
  assign v1 = {v2[31:16], v0[31:16]};
  assign v3 = {v2[15:0], v0[15:0]};

  logic [7:0] ks_byte;
  assign ks_byte = ks[pos[3:2]][8*pos[1:0] +: 8];

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job <= J_DATA;
      key_low <= '0;
      key_high <= '0;
      iv_value <= '0;
      carry <= 1'b0;
      mcarry <= 1'b0;
      pos <= '0;
      idx <= '0;
      iter <= '0;
      out_ch.valid <= 1'b0;
      out_ch.out_byte <= '0;
      out_ch.is_data <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        x[i] <= '0;
        c[i] <= '0;
        mx[i] <= '0;
        mc[i] <= '0;
      end
      for (int i = 0; i < 4; i++) ks[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rsc_pkg::REG_KEY_LOW: key_low <= cfg_data;
          rsc_pkg::REG_KEY_HIGH: key_high <= cfg_data;
          rsc_pkg::REG_IV: iv_value <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            dbyte <= in_ch.data_byte;
            idx <= '0;
            iter <= '0;
            case (in_ch.command)
              rsc_pkg::CMD_DATA: begin
                job <= J_DATA;
                state <= (pos == 4'd0) ? S_CNT : S_DECIDE;
              end
              rsc_pkg::CMD_KEY: begin
                job <= J_KEY;
                x[0] <= k0;
                x[2] <= k1;
                x[4] <= k2;
                x[6] <= k3;
                x[1] <= {k3[15:0], k2[31:16]};
                x[3] <= {k0[15:0], k3[31:16]};
                x[5] <= {k1[15:0], k0[31:16]};
                x[7] <= {k2[15:0], k1[31:16]};
                c[0] <= rsc_pkg::rol16(k2);
                c[2] <= rsc_pkg::rol16(k3);
                c[4] <= rsc_pkg::rol16(k0);
                c[6] <= rsc_pkg::rol16(k1);
                c[1] <= (k0 & rsc_pkg::HI_MASK) | (k1 & rsc_pkg::LO_MASK);
                c[3] <= (k1 & rsc_pkg::HI_MASK) | (k2 & rsc_pkg::LO_MASK);
                c[5] <= (k2 & rsc_pkg::HI_MASK) | (k3 & rsc_pkg::LO_MASK);
                c[7] <= (k3 & rsc_pkg::HI_MASK) | (k0 & rsc_pkg::LO_MASK);
                carry <= 1'b0;
                state <= S_CNT;
              end
              rsc_pkg::CMD_IV: begin
                job <= J_IV;
                c[0] <= mc[0] ^ v0;
                c[1] <= mc[1] ^ v1;
                c[2] <= mc[2] ^ v2;
                c[3] <= mc[3] ^ v3;
                c[4] <= mc[4] ^ v0;
                c[5] <= mc[5] ^ v1;
                c[6] <= mc[6] ^ v2;
                c[7] <= mc[7] ^ v3;
                for (int i = 0; i < 8; i++) x[i] <= mx[i];
                carry <= mcarry;
                state <= S_CNT;
              end
              default: begin
                job <= J_KEY;
                // Unused code: acknowledge only.
                out_ch.valid <= 1'b1;
                out_ch.out_byte <= '0;
                out_ch.is_data <= 1'b0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_DECIDE: begin
          out_ch.valid <= 1'b1;
          out_ch.out_byte <= dbyte ^ ks_byte;
          out_ch.is_data <= 1'b1;
          pos <= pos + 4'd1;
          state <= S_OUT;
        end
        S_CNT: begin
          c[idx] <= cnt_sum[31:0];
          carry <= cnt_sum[32];
          idx <= idx + 3'd1;
          if (idx == 3'd7) state <= S_SQ;
        end
        S_SQ: begin
          sq <= 64'(sq_in) * 64'(sq_in);
          state <= S_SQW;
        end
        S_SQW: begin
          g[idx] <= sq[63:32] ^ sq[31:0];
          idx <= idx + 3'd1;
          state <= (idx == 3'd7) ? S_MIX : S_SQ;
        end
        S_MIX: begin
          x[idx] <= mix_val;
          idx <= idx + 3'd1;
          if (idx == 3'd7) state <= S_ITDONE;
        end
        S_ITDONE: begin
          iter <= iter + 2'd1;
          if (job == J_DATA) begin
            ks[0] <= x[0] ^ {16'd0, x[5][31:16]} ^ {x[3][15:0], 16'd0};
            ks[1] <= x[2] ^ {16'd0, x[7][31:16]} ^ {x[5][15:0], 16'd0};
            ks[2] <= x[4] ^ {16'd0, x[1][31:16]} ^ {x[7][15:0], 16'd0};
            ks[3] <= x[6] ^ {16'd0, x[3][31:16]} ^ {x[1][15:0], 16'd0};
            state <= S_DECIDE;
          end else if (iter != 2'd3) begin
            state <= S_CNT;
          end else if (job == J_KEY) begin
            state <= S_FIX;
          end else begin
            state <= S_KS;
          end
        end
        S_FIX: begin
          c[idx] <= c[idx] ^ x[idx + 3'd4];
          idx <= idx + 3'd1;
          if (idx == 3'd7) state <= S_KS;
        end
        S_KS: begin
          if (job == J_KEY) begin
            for (int i = 0; i < 8; i++) begin
              mx[i] <= x[i];
              mc[i] <= c[i];
            end
            mcarry <= carry;
          end
          for (int i = 0; i < 4; i++) ks[i] <= '0;
          pos <= '0;
          out_ch.valid <= 1'b1;
          out_ch.out_byte <= '0;
          out_ch.is_data <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused_eoc;
  assign unused_eoc = in_ch.end_of_call;

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_OUT) else $error("result outside output state");
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |=> pos == $past(pos) + 4'd1) else $error("position slip");
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready) |=> state == S_IDLE) else $error("no return to idle");
endmodule
`default_nettype wire
